// ===== rtl/sdp_pkg.sv =====
package sdp_pkg;

  // Working word of the datapath: every intermediate fits in 64 signed bits.
  typedef logic signed [63:0] dword_t;

  // Shift of the reciprocal used for exact division by a constant.
  localparam int RecipShift = 84;
  localparam int RecipWidth = 76;

  localparam int TempWidth = 20;
  localparam int SalWidth  = 19;
  localparam int DensWidth = 27;

  localparam int SqrtInWidth = 60;
  localparam int SqrtStages  = 15;

  localparam longint OutLow  = -64'sd16000000;
  localparam longint OutHigh = 64'sd40000000;

endpackage

// ===== rtl/sdp_mul_rnd.sv =====
module sdp_mul_rnd #(
  parameter longint Div = 10000
) (
  input  logic           clk,
  input  logic           en,
  input  sdp_pkg::dword_t a,
  input  sdp_pkg::dword_t b,
  input  sdp_pkg::dword_t add,
  output sdp_pkg::dword_t y
);
  import sdp_pkg::*;

  // y = rnd(a * b / Div) + add, six register stages, 32x32 multipliers only.
  localparam logic [RecipWidth-1:0] Recip = RecipWidth'(
    ((141'(1) << RecipShift) + 141'(Div) - 141'(1)) / 141'(Div));
  localparam logic [63:0] Half    = 64'(Div / 2);
  localparam logic [63:0] HalfInc = 64'(Div / 2 + 1);
  localparam logic [31:0] R0 = Recip[31:0];
  localparam logic [31:0] R1 = Recip[63:32];
  localparam logic [RecipWidth-65:0] R2 = Recip[RecipWidth-1:64];

  logic [63:0] ab_ll;
  logic [31:0] ab_lh;
  logic [31:0] ab_hl;
  logic [63:0] mr00;
  logic [63:0] mr01;
  logic [63:0] mr10;
  logic [63:0] mr11;
  logic [RecipWidth-33:0] mr02;
  logic [RecipWidth-33:0] mr12;

  logic [63:0] pp_ll;
  logic [31:0] pp_lh;
  logic [31:0] pp_hl;
  logic [63:0] p;
  logic [63:0] m;
  logic neg_m;
  logic neg_w;
  logic neg_q;
  logic [63:0] w0;
  logic [64:0] w1;
  logic [64:0] w2;
  logic [RecipWidth-33:0] w3;
  logic [63+RecipWidth:0] total;
  logic [63+RecipWidth-RecipShift:0] quo;
  dword_t add_d [0:4];
  dword_t quo_s;
  dword_t y_next;

  // Partial products; only the low 64 bits of a * b are kept.
  always_comb begin
    ab_ll = a[31:0] * b[31:0];
    ab_lh = a[31:0] * b[63:32];
    ab_hl = a[63:32] * b[31:0];
    mr00  = m[31:0] * R0;
    mr01  = m[31:0] * R1;
    mr10  = m[63:32] * R0;
    mr11  = m[63:32] * R1;
    mr02  = m[31:0] * R2;
    mr12  = m[63:32] * R2;
  end

  always_comb begin
    total = (64+RecipWidth)'(w0) +
            (64+RecipWidth)'({w1, 32'b0}) +
            (64+RecipWidth)'({w2, 64'b0}) +
            (64+RecipWidth)'({w3, 96'b0});
    quo_s  = dword_t'(64'(quo));
    y_next = neg_q ? add_d[4] - quo_s : add_d[4] + quo_s;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // product limbs
      pp_ll    <= ab_ll;
      pp_lh    <= ab_lh;
      pp_hl    <= ab_hl;
      add_d[0] <= add;
      // product
      p        <= pp_ll + {pp_lh + pp_hl, 32'b0};
      add_d[1] <= add_d[0];
      // magnitude plus half, ties away from zero
      m        <= p[63] ? ~p + HalfInc : p + Half;
      neg_m    <= p[63];
      add_d[2] <= add_d[1];
      // reciprocal product by weight
      w0       <= mr00;
      w1       <= 65'(mr01) + 65'(mr10);
      w2       <= 65'(mr02) + 65'(mr11);
      w3       <= mr12;
      neg_w    <= neg_m;
      add_d[3] <= add_d[2];
      // quotient
      quo      <= total[63+RecipWidth:RecipShift];
      neg_q    <= neg_w;
      add_d[4] <= add_d[3];
      // restore sign and add
      y        <= y_next;
    end
  end

endmodule

// ===== rtl/sdp_delay.sv =====
module sdp_delay #(
  parameter int Width = 64,
  parameter int Depth = 4
) (
  input  logic             clk,
  input  logic             en,
  input  logic [Width-1:0] d,
  output logic [Width-1:0] q
);

  logic [Width-1:0] taps [0:Depth-1];

  always_ff @(posedge clk) begin
    if (en) begin
      taps[0] <= d;
      for (int i = 1; i < Depth; i++) begin
        taps[i] <= taps[i-1];
      end
    end
  end

  assign q = taps[Depth-1];

endmodule

// ===== rtl/sdp_sqrt.sv =====
module sdp_sqrt (
  input  logic                            clk,
  input  logic                            en,
  input  logic [sdp_pkg::SqrtInWidth-1:0] x,
  output sdp_pkg::dword_t                 root
);
  import sdp_pkg::*;

  typedef struct packed {
    logic [60:0] rem;
    logic [60:0] acc;
  } sq_t;

  function automatic sq_t sq_step(sq_t st, int unsigned sh);
    logic [60:0] bitv;
    logic [60:0] trial;
    sq_t res;
    bitv  = 61'(1) << sh;
    trial = st.acc + bitv;
    if (st.rem >= trial) begin
      res.rem = st.rem - trial;
      res.acc = (st.acc >> 1) + bitv;
    end else begin
      res.rem = st.rem;
      res.acc = st.acc >> 1;
    end
    return res;
  endfunction

  sq_t st [0:SqrtStages-1];
  logic [60:0] fin_next;

  // Two result bits per stage, most significant first.
  for (genvar j = 0; j < SqrtStages; j++) begin : g_stage
    sq_t src;
    sq_t mid;
    if (j == 0) begin : g_first
      assign src = '{rem: 61'(x), acc: 61'(0)};
    end else begin : g_next
      assign src = st[j-1];
    end
    assign mid = sq_step(src, 2 * (29 - 2 * j));
    always_ff @(posedge clk) begin
      if (en) begin
        st[j] <= sq_step(mid, 2 * (28 - 2 * j));
      end
    end
  end

  // Round to nearest: step up when the remainder exceeds the root.
  assign fin_next = st[SqrtStages-1].acc +
                    61'(st[SqrtStages-1].rem > st[SqrtStages-1].acc);

  always_ff @(posedge clk) begin
    if (en) begin
      root <= dword_t'(fin_next);
    end
  end

endmodule

// ===== rtl/seawater_density_polynomial_core.sv =====
// Throughput: one item per cycle; the whole pipeline advances together and
// holds while the output register is full and m_axis_tready is low.
// The pure-water Horner chain (six multiply-round steps)
// sets the pipeline depth.
// Reset (rst, synchronous, active high) clears every valid bit; data holds.
module seawater_density_polynomial_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // temperature[19:0], salinity[38:20], zero pad
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata   // density_anomaly[26:0], zero pad
);
  import sdp_pkg::*;

  localparam int Last = 44;

  // Pure-water coefficients, 1e-15 (CW2, CW1 in 1e-12).
  localparam dword_t CW6 = 64'sd6536332;
  localparam dword_t CW5 = 64'sd1120083000;
  localparam dword_t CW4 = 64'sd100168500000;
  localparam dword_t CW3 = 64'sd9095290000000;
  localparam dword_t CW2 = 64'sd67939520000;
  localparam dword_t CW1 = 64'sd157406000000;
  // Linear salinity coefficients, 1e-13.
  localparam dword_t CB5 = 64'sd53875;
  localparam dword_t CB4 = 64'sd8246700;
  localparam dword_t CB3 = 64'sd764380000;
  localparam dword_t CB2 = 64'sd40899000000;
  localparam dword_t CB1 = 64'sd8244930000000;
  // Salinity^1.5 coefficients, 1e-10.
  localparam dword_t CC3 = 64'sd16546;
  localparam dword_t CC2 = 64'sd1022700;
  localparam dword_t CC1 = 64'sd57246600;
  // Salinity^2 coefficient, 1e-8.
  localparam dword_t CD1 = 64'sd48314;
  localparam dword_t One = 64'sd1;
  localparam dword_t Zero = 64'sd0;

  logic en;
  logic vld [0:Last];

  logic signed [TempWidth-1:0] tp [0:30];
  logic [SalWidth-1:0]         sp [0:24];

  logic [SqrtInWidth-1:0] x_sq;
  dword_t ss;

  dword_t h1, h2, h3, h4, h5, h6;
  dword_t b1, b2, b3, b4, bt;
  dword_t c1, c2, cd;
  dword_t dt, q, s15, ct;
  dword_t ct_d, bt_d, dt_d;
  dword_t sum, fin;
  logic signed [DensWidth-1:0] dens;
  logic signed [DensWidth-1:0] dens_next;

  // Advance whenever the output register is free or being taken.
  assign en            = !vld[Last] || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld[Last];
  assign m_axis_tdata  = {5'b0, dens};

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i <= Last; i++) begin
        vld[i] <= 1'b0;
      end
    end else if (en) begin
      vld[0] <= s_axis_tvalid;
      for (int i = 1; i <= Last; i++) begin
        vld[i] <= vld[i-1];
      end
    end
  end

  // Input register, operand delay lines and the salinity products for the square root and squared term.
  always_ff @(posedge clk) begin
    if (en) begin
      tp[0] <= s_axis_tdata[19:0];
      sp[0] <= s_axis_tdata[38:20];
      for (int i = 1; i <= 30; i++) begin
        tp[i] <= tp[i-1];
      end
      for (int i = 1; i <= 24; i++) begin
        sp[i] <= sp[i-1];
      end
      x_sq <= SqrtInWidth'(64'(sp[0]) * 64'd1000000000000);
      ss   <= dword_t'(64'(sp[0]) * 64'(sp[0]));
    end
  end

  function automatic dword_t tx(logic signed [TempWidth-1:0] v);
    return dword_t'(v);
  endfunction

  function automatic dword_t sx(logic [SalWidth-1:0] v);
    return dword_t'({45'b0, v});
  endfunction

  // Pure water, Horner form.
  sdp_mul_rnd #(.Div(10000)) u_h1 (.clk, .en, .a(CW6), .b(tx(tp[0])), .add(-CW5), .y(h1));
  sdp_mul_rnd #(.Div(10000)) u_h2 (.clk, .en, .a(h1), .b(tx(tp[6])), .add(CW4), .y(h2));
  sdp_mul_rnd #(.Div(10000)) u_h3 (.clk, .en, .a(h2), .b(tx(tp[12])), .add(-CW3), .y(h3));
  sdp_mul_rnd #(.Div(1000))  u_h4 (.clk, .en, .a(h3), .b(One), .add(Zero), .y(h4));
  sdp_mul_rnd #(.Div(10000)) u_h5 (.clk, .en, .a(h4), .b(tx(tp[24])), .add(CW2), .y(h5));
  sdp_mul_rnd #(.Div(10000)) u_h6 (.clk, .en, .a(h5), .b(tx(tp[30])), .add(-CW1), .y(h6));

  // Linear salinity coefficient and its term.
  sdp_mul_rnd #(.Div(10000))  u_b1 (.clk, .en, .a(CB5), .b(tx(tp[0])), .add(-CB4), .y(b1));
  sdp_mul_rnd #(.Div(10000))  u_b2 (.clk, .en, .a(b1), .b(tx(tp[6])), .add(CB3), .y(b2));
  sdp_mul_rnd #(.Div(10000))  u_b3 (.clk, .en, .a(b2), .b(tx(tp[12])), .add(-CB2), .y(b3));
  sdp_mul_rnd #(.Div(10000))  u_b4 (.clk, .en, .a(b3), .b(tx(tp[18])), .add(CB1), .y(b4));
  sdp_mul_rnd #(.Div(100000)) u_bt (.clk, .en, .a(b4), .b(sx(sp[24])), .add(Zero), .y(bt));

  // Salinity^1.5 coefficient.
  sdp_mul_rnd #(.Div(10000)) u_c1 (.clk, .en, .a(-CC3), .b(tx(tp[0])), .add(CC2), .y(c1));
  sdp_mul_rnd #(.Div(10000)) u_c2 (.clk, .en, .a(c1), .b(tx(tp[6])), .add(-CC1), .y(c2));

  // Salinity squared term.
  sdp_mul_rnd #(.Div(10000)) u_dt (.clk, .en, .a(ss), .b(CD1), .add(Zero), .y(dt));

  // Square root of salinity, then s^1.5 and its term.
  sdp_sqrt u_sqrt (.clk, .en, .x(x_sq), .root(q));
  sdp_mul_rnd #(.Div(10000))   u_s15 (.clk, .en, .a(sx(sp[17])), .b(q), .add(Zero), .y(s15));
  sdp_delay #(.Width(64), .Depth(11)) u_cd (.clk, .en, .d(c2), .q(cd));
  sdp_mul_rnd #(.Div(1000000)) u_ct (.clk, .en, .a(cd), .b(s15), .add(Zero), .y(ct));

  // Align the earlier terms with the pure-water term.
  sdp_delay #(.Width(64), .Depth(7))  u_ctd (.clk, .en, .d(ct), .q(ct_d));
  sdp_delay #(.Width(64), .Depth(6))  u_btd (.clk, .en, .d(bt), .q(bt_d));
  sdp_delay #(.Width(64), .Depth(29)) u_dtd (.clk, .en, .d(dt), .q(dt_d));

  always_ff @(posedge clk) begin
    if (en) begin
      sum <= (h6 + bt_d) + (ct_d + dt_d);
    end
  end

  sdp_mul_rnd #(.Div(1000000)) u_fin (.clk, .en, .a(sum), .b(One), .add(Zero), .y(fin));

  // Saturate to the stated output range.
  always_comb begin
    if (fin < OutLow) begin
      dens_next = DensWidth'(OutLow);
    end else if (fin > OutHigh) begin
      dens_next = DensWidth'(OutHigh);
    end else begin
      dens_next = DensWidth'(fin);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dens <= dens_next;
    end
  end

endmodule

// ===== verif/seawater_density_polynomial_core_tb.sv =====
`timescale 1ns / 1ps

module seawater_density_polynomial_core_tb;
  import sdp_pkg::*;

  localparam int Latency   = 44;
  localparam int MaxCycles = 400000;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata;   // temperature[19:0], salinity[38:20], zero pad
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;   // density_anomaly[26:0], zero pad

  // Idle rates in percent for each side; updated per test phase.
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;

  logic [DensWidth-1:0] density_queue[$];
  int unsigned mismatch_count;
  int unsigned result_count;
  int unsigned item_count;
  int unsigned cycle_count;
  int unsigned sat_low_count;
  int unsigned sat_high_count;

  seawater_density_polynomial_core uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Round to nearest, ties away from zero.
  function automatic longint div_round(longint num, longint den);
    if (num >= 0) begin
      return (num + den / 2) / den;
    end
    return -((-num + den / 2) / den);
  endfunction

  // Nearest integer square root of a 64-bit unsigned value.
  function automatic longint unsigned root_nearest(longint unsigned x);
    longint unsigned rem;
    longint unsigned root;
    longint unsigned bitv;
    rem  = x;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > rem) bitv >>= 2;
    while (bitv != 0) begin
      if (rem >= root + bitv) begin
        rem -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    if (rem > root) root += 1;
    return root;
  endfunction

  // Density anomaly in 1e-6 kg/m3 from raw temperature and salinity codes.
  function automatic logic [DensWidth-1:0] density_anomaly(
      logic [TempWidth-1:0] temp_raw, logic [SalWidth-1:0] sal_raw);
    longint t;
    longint s;
    longint h;
    longint b;
    longint c;
    longint q;
    longint s15;
    longint sum;
    longint res;
    t = longint'(signed'(temp_raw));
    s = longint'(sal_raw);
    // pure water, Horner form; drop three decimals after h3
    h = div_round(64'sd6536332 * t, 10000) - 64'sd1120083000;
    h = div_round(h * t, 10000) + 64'sd100168500000;
    h = div_round(h * t, 10000) - 64'sd9095290000000;
    h = div_round(h, 1000);
    h = div_round(h * t, 10000) + 64'sd67939520000;
    h = div_round(h * t, 10000) - 64'sd157406000000;
    // linear salinity coefficient
    b = div_round(64'sd53875 * t, 10000) - 64'sd8246700;
    b = div_round(b * t, 10000) + 64'sd764380000;
    b = div_round(b * t, 10000) - 64'sd40899000000;
    b = div_round(b * t, 10000) + 64'sd8244930000000;
    sum = h + div_round(b * s, 100000);
    // salinity to the power 1.5, squared term and final rounding
    c = div_round(-64'sd16546 * t, 10000) + 64'sd1022700;
    c = div_round(c * t, 10000) - 64'sd57246600;
    q = longint'(root_nearest(longint'(s) * 64'd1000000000000));
    s15 = div_round(s * q, 10000);
    sum += div_round(c * s15, 1000000);
    sum += div_round(64'sd48314 * s * s, 10000);
    res = div_round(sum, 1000000);
    if (res < OutLow) res = OutLow;
    if (res > OutHigh) res = OutHigh;
    return res[DensWidth-1:0];
  endfunction

  // Cycle counter and timeout.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= MaxCycles) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Receiver: random stall on tready, compare each transfer with the oldest expectation.
  always @(posedge clk) begin
    logic [DensWidth-1:0] want;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        result_count <= result_count + 1;
        if (density_queue.size() == 0) begin
          mismatch_count <= mismatch_count + 1;
          if (mismatch_count < 10)
            $display("Unexpected result %h", m_axis_tdata);
        end else begin
          want = density_queue.pop_front();
          if (m_axis_tdata !== {5'd0, want}) begin
            mismatch_count <= mismatch_count + 1;
            if (mismatch_count < 10)
              $display("Density mismatch: expected %0d got %0d (raw %h)",
                       signed'(want), signed'(m_axis_tdata[DensWidth-1:0]),
                       m_axis_tdata);
          end
        end
      end
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Send one item; hold tvalid across back-to-back transfers.
  task automatic send_sample(logic [TempWidth-1:0] temp_raw, logic [SalWidth-1:0] sal_raw);
    logic [DensWidth-1:0] d;
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, sal_raw, temp_raw};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    d = density_anomaly(temp_raw, sal_raw);
    if (signed'(d) == OutLow) sat_low_count++;
    if (signed'(d) == OutHigh) sat_high_count++;
    density_queue.push_back(d);
    item_count++;
  endtask

  task automatic release_bus();
    s_axis_tvalid <= 1'b0;
  endtask

  task automatic drain_results();
    release_bus();
    while (density_queue.size() != 0) @(posedge clk);
  endtask

  // Field extremes and in-range corners, full bit patterns included.
  task automatic test_extremes();
    logic [TempWidth-1:0] temps[6];
    logic [SalWidth-1:0]  sals[5];
    temps = '{20'(-25000), 20'd0, 20'd450000, 20'h7FFFF, 20'h80000, 20'hFFFFF};
    sals  = '{19'd0, 19'd1, 19'd350000, 19'd450000, 19'h7FFFF};
    foreach (temps[i]) begin
      foreach (sals[j]) begin
        if ((i + j) % 2 == 0 || i < 2) send_sample(temps[i], sals[j]);
      end
    end
    // drive the output towards both saturation limits
    send_sample(20'h80000, 19'h7FFFF);
    send_sample(20'h7FFFF, 19'd0);
    send_sample(20'd40000, 19'd0);
  endtask

  // Pause the sender until every expected result has come.
  task automatic test_pause_drain();
    send_sample(20'd150000, 19'd350000);
    drain_results();
    send_sample(20'd100000, 19'd200000);
  endtask

  // Mostly realistic ranges, some full-width noise.
  task automatic test_random(int unsigned count);
    logic [TempWidth-1:0] t;
    logic [SalWidth-1:0]  s;
    repeat (count) begin
      if ($urandom_range(9) < 8) begin
        t = 20'($signed($urandom_range(475000)) - 25000);
        s = 19'($urandom_range(450000));
      end else begin
        t = 20'($urandom);
        s = 19'($urandom);
      end
      send_sample(t, s);
    end
  endtask

  initial begin
    rst            = 1'b1;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    m_axis_tready  = 1'b0;
    send_idle_pct  = 0;
    recv_idle_pct  = 0;
    mismatch_count = 0;
    result_count   = 0;
    item_count     = 0;
    cycle_count    = 0;
    sat_low_count  = 0;
    sat_high_count = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_idle_pct = 8;
    recv_idle_pct = 53;
    test_extremes();
    test_pause_drain();
    test_random(180);
    send_idle_pct = 53;
    recv_idle_pct = 8;
    test_random(180);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(180);

    drain_results();
    repeat (Latency + 10) @(posedge clk);

    $display("Covered %0d samples, %0d results; %0d saturated low, %0d saturated high.",
             item_count, result_count, sat_low_count, sat_high_count);
    $display("Idle phases: sender-light, receiver-light, none; %0d mismatches.",
             mismatch_count);
    if (mismatch_count == 0 && density_queue.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
